// ----- sv/scc_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the sector cache clock controller.
// Holds default sizes, opcodes, datapath commands and the status bundle.
// Used by scc_ctrl, scc_dp and sector_cache_clock_controller.
package scc_pkg;

    localparam int DEF_SLOT_COUNT   = 64;
    localparam int DEF_SECTOR_BYTES = 512;
    localparam int DEF_SECTOR_BITS  = 32;
    localparam int OPCODE_W         = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_REJECT,
        CMD_LOOKUP_STEP,
        CMD_HIT,
        CMD_MISS_SETUP,
        CMD_EVICT_STEP,
        CMD_EVICT_PICK,
        CMD_VICTIM_READ,
        CMD_COMMIT,
        CMD_FLUSH_STEP,
        CMD_FLUSH_END
    } t_cmd;

    typedef struct packed {
        logic is_flush;
        logic reject;
        logic hit;
        logic scan_done;
        logic free_found;
        logic ev_sel;
        logic out_free;
        logic flush_stall;
    } t_status;

endpackage

// ----- sv/scc_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the sector cache clock controller: tag memory, status bits,
// scan and clock pointers, and the result register.
// Depends on scc_pkg; driven by commands from scc_ctrl.
module scc_dp #(
    parameter int SLOT_COUNT   = scc_pkg::DEF_SLOT_COUNT,
    parameter int SECTOR_BYTES = scc_pkg::DEF_SECTOR_BYTES,
    parameter int SECTOR_BITS  = scc_pkg::DEF_SECTOR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  scc_pkg::t_cmd                       i_cmd,
    output scc_pkg::t_status                    o_status,
    input  logic [scc_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [SECTOR_BITS-1:0]              i_sector,
    input  logic [$clog2(SECTOR_BYTES)-1:0]     i_byte_offset,
    input  logic [$clog2(SECTOR_BYTES+1)-1:0]   i_byte_count,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [$clog2(SLOT_COUNT)-1:0]       o_slot,
    output logic                                o_hit,
    output logic                                o_fill_needed,
    output logic                                o_writeback_needed,
    output logic [SECTOR_BITS-1:0]              o_writeback_sector,
    output logic                                o_rejected,
    output logic                                o_final_result
);
    import scc_pkg::*;

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int OW   = $clog2(SECTOR_BYTES);
    localparam int CW   = $clog2(SECTOR_BYTES + 1);
    localparam int SUMW = CW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    // Request latch.
    logic [OPCODE_W-1:0]    r_op;
    logic [SECTOR_BITS-1:0] r_sec;
    logic [OW-1:0]          r_off;
    logic [CW-1:0]          r_cnt;

    // Tag memory and per-slot status bits.
    logic [SECTOR_BITS-1:0] r_tag_mem [SLOT_COUNT];
    logic [SECTOR_BITS-1:0] r_rd_tag;
    logic [SLOT_COUNT-1:0]  r_valid;
    logic [SLOT_COUNT-1:0]  r_dirty;
    logic [SLOT_COUNT-1:0]  r_ref;

    // Scan, clock and victim state.
    logic [SW-1:0] r_idx;
    logic          r_issue_done;
    logic          r_cmp_vld;
    logic [SW-1:0] r_cmp_idx;
    logic          r_free_found;
    logic [SW-1:0] r_free_idx;
    logic [SW-1:0] r_hand;
    logic [SW-1:0] r_ptr;
    logic [SW-1:0] r_step;
    logic [1:0]    r_round;
    logic [SW-1:0] r_victim;
    logic          r_evicting;
    logic          r_pend;
    logic [SW-1:0] r_pend_slot;
    logic [SECTOR_BITS-1:0] r_pend_tag;

    // Result register.
    logic                   r_o_vld;
    logic [SW-1:0]          r_o_slot;
    logic                   r_o_hit;
    logic                   r_o_fill;
    logic                   r_o_wb;
    logic [SECTOR_BITS-1:0] r_o_wbsec;
    logic                   r_o_rej;
    logic                   r_o_fin;

    logic [SUMW-1:0] w_sum;
    logic            w_out_free;
    logic            w_o_load;
    logic            w_mem_re;
    logic            w_mem_we;
    logic [SW-1:0]   w_rd_addr;
    logic [SW-1:0]   w_hand_next;
    logic            w_victim_wb;
    logic            w_full_write;

    assign w_sum        = SUMW'(r_off) + SUMW'(r_cnt);
    assign w_out_free   = !r_o_vld || i_out_ready;
    // A new result enters the output register in this cycle.
    assign w_o_load     = (i_cmd == CMD_REJECT) || (i_cmd == CMD_HIT)
                          || (i_cmd == CMD_COMMIT) || (i_cmd == CMD_FLUSH_END)
                          || ((i_cmd == CMD_FLUSH_STEP) && r_cmp_vld && r_pend);
    assign w_mem_re     = ((i_cmd == CMD_LOOKUP_STEP || i_cmd == CMD_FLUSH_STEP)
                           && !r_issue_done) || (i_cmd == CMD_VICTIM_READ);
    assign w_mem_we     = (i_cmd == CMD_COMMIT);
    assign w_rd_addr    = (i_cmd == CMD_VICTIM_READ) ? r_victim : r_idx;
    assign w_hand_next  = (r_victim == LAST_SLOT) ? '0 : r_victim + 1'b1;
    assign w_victim_wb  = r_dirty[r_victim];
    assign w_full_write = (r_off == '0) && (r_cnt == CW'(SECTOR_BYTES));

    assign o_status.is_flush    = (r_op == OP_FLUSH);
    assign o_status.reject      = !(r_op == OP_READ || r_op == OP_WRITE)
                                  || (w_sum > SUMW'(SECTOR_BYTES));
    assign o_status.hit         = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_tag == r_sec);
    assign o_status.scan_done   = r_issue_done && !r_cmp_vld;
    assign o_status.free_found  = r_free_found;
    assign o_status.ev_sel      = r_round[0] ? r_dirty[r_ptr]
                                             : (!r_ref[r_ptr] && !r_dirty[r_ptr]);
    assign o_status.out_free    = w_out_free;
    assign o_status.flush_stall = r_cmp_vld && r_pend && !w_out_free;

    assign o_out_valid        = r_o_vld;
    assign o_slot             = r_o_slot;
    assign o_hit              = r_o_hit;
    assign o_fill_needed      = r_o_fill;
    assign o_writeback_needed = r_o_wb;
    assign o_writeback_sector = r_o_wbsec;
    assign o_rejected         = r_o_rej;
    assign o_final_result     = r_o_fin;

    // Tag memory: one write or one read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_tag_mem[r_victim] <= r_sec;
        end
        if (w_mem_re) begin
            r_rd_tag <= r_tag_mem[w_rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_dirty      <= '0;
            r_ref        <= '0;
            r_hand       <= '0;
            r_o_vld      <= 1'b0;
            r_idx        <= '0;
            r_issue_done <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_cmp_idx    <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_ptr        <= '0;
            r_step       <= '0;
            r_round      <= '0;
            r_victim     <= '0;
            r_evicting   <= 1'b0;
            r_pend       <= 1'b0;
            r_pend_slot  <= '0;
        end else begin
            if (w_o_load) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
            case (i_cmd)
                CMD_ACCEPT: begin
                    r_idx        <= '0;
                    r_issue_done <= 1'b0;
                    r_cmp_vld    <= 1'b0;
                    r_free_found <= 1'b0;
                    r_pend       <= 1'b0;
                end
                CMD_LOOKUP_STEP: begin
                    if (!r_issue_done) begin
                        r_cmp_vld    <= 1'b1;
                        r_cmp_idx    <= r_idx;
                        r_idx        <= r_idx + 1'b1;
                        r_issue_done <= (r_idx == LAST_SLOT);
                        if (!r_free_found && !r_valid[r_idx]) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_idx;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                end
                CMD_HIT: begin
                    if (r_op == OP_READ) begin
                        r_ref[r_cmp_idx] <= 1'b1;
                    end else begin
                        r_dirty[r_cmp_idx] <= 1'b1;
                    end
                end
                CMD_MISS_SETUP: begin
                    r_victim   <= r_free_idx;
                    r_ptr      <= r_hand;
                    r_round    <= '0;
                    r_step     <= '0;
                    r_evicting <= !r_free_found;
                end
                CMD_EVICT_STEP: begin
                    if (r_round == 2'd1) begin
                        r_ref[r_ptr] <= 1'b0;
                    end
                    r_ptr <= (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
                    if (r_step == LAST_SLOT) begin
                        r_step  <= '0;
                        r_round <= r_round + 1'b1;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                CMD_EVICT_PICK: begin
                    r_victim <= r_ptr;
                end
                CMD_COMMIT: begin
                    r_valid[r_victim] <= 1'b1;
                    r_dirty[r_victim] <= (r_op == OP_WRITE);
                    r_ref[r_victim]   <= (r_op == OP_READ);
                    if (r_evicting) begin
                        r_hand <= w_hand_next;
                    end
                end
                CMD_FLUSH_STEP: begin
                    if (r_cmp_vld) begin
                        r_dirty[r_cmp_idx] <= 1'b0;
                        r_pend             <= 1'b1;
                        r_pend_slot        <= r_cmp_idx;
                    end
                    if (!r_issue_done) begin
                        r_cmp_vld    <= r_valid[r_idx] && r_dirty[r_idx];
                        r_cmp_idx    <= r_idx;
                        r_idx        <= r_idx + 1'b1;
                        r_issue_done <= (r_idx == LAST_SLOT);
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_ACCEPT: begin
                r_op  <= i_opcode;
                r_sec <= i_sector;
                r_off <= i_byte_offset;
                r_cnt <= i_byte_count;
            end
            CMD_REJECT: begin
                r_o_slot  <= '0;
                r_o_hit   <= 1'b0;
                r_o_fill  <= 1'b0;
                r_o_wb    <= 1'b0;
                r_o_wbsec <= '0;
                r_o_rej   <= 1'b1;
                r_o_fin   <= 1'b1;
            end
            CMD_HIT: begin
                r_o_slot  <= r_cmp_idx;
                r_o_hit   <= 1'b1;
                r_o_fill  <= 1'b0;
                r_o_wb    <= 1'b0;
                r_o_wbsec <= '0;
                r_o_rej   <= 1'b0;
                r_o_fin   <= 1'b1;
            end
            CMD_COMMIT: begin
                r_o_slot  <= r_victim;
                r_o_hit   <= 1'b0;
                r_o_fill  <= (r_op == OP_READ) || !w_full_write;
                r_o_wb    <= w_victim_wb;
                r_o_wbsec <= w_victim_wb ? r_rd_tag : '0;
                r_o_rej   <= 1'b0;
                r_o_fin   <= 1'b1;
            end
            CMD_FLUSH_STEP: begin
                if (r_cmp_vld) begin
                    r_pend_tag <= r_rd_tag;
                    if (r_pend) begin
                        r_o_slot  <= r_pend_slot;
                        r_o_hit   <= 1'b0;
                        r_o_fill  <= 1'b0;
                        r_o_wb    <= 1'b1;
                        r_o_wbsec <= r_pend_tag;
                        r_o_rej   <= 1'b0;
                        r_o_fin   <= 1'b0;
                    end
                end
            end
            CMD_FLUSH_END: begin
                r_o_slot  <= r_pend ? r_pend_slot : '0;
                r_o_hit   <= 1'b0;
                r_o_fill  <= 1'b0;
                r_o_wb    <= r_pend;
                r_o_wbsec <= r_pend ? r_pend_tag : '0;
                r_o_rej   <= 1'b0;
                r_o_fin   <= 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- sv/scc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the sector cache clock controller: sequences lookup,
// eviction, fill commit and flush by issuing commands to scc_dp.
// Depends on scc_pkg.
module scc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  scc_pkg::t_status i_status,
    output scc_pkg::t_cmd    o_cmd,
    output logic             o_in_ready
);
    import scc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_REJ,
        S_LOOKUP,
        S_HIT,
        S_MISS,
        S_EVICT,
        S_VREAD,
        S_COMMIT,
        S_FLUSH,
        S_FEND
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_rdy;
    t_cmd   w_cmd;

    assign o_cmd      = w_cmd;
    assign o_in_ready = r_in_rdy;

    always_comb begin
        n_state = r_state;
        w_cmd   = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_rdy) begin
                    w_cmd   = CMD_ACCEPT;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.is_flush) begin
                    n_state = S_FLUSH;
                end else if (i_status.reject) begin
                    n_state = S_REJ;
                end else begin
                    n_state = S_LOOKUP;
                end
            end
            S_REJ: begin
                if (i_status.out_free) begin
                    w_cmd   = CMD_REJECT;
                    n_state = S_IDLE;
                end
            end
            S_LOOKUP: begin
                if (i_status.hit) begin
                    n_state = S_HIT;
                end else if (i_status.scan_done) begin
                    n_state = S_MISS;
                end else begin
                    w_cmd = CMD_LOOKUP_STEP;
                end
            end
            S_HIT: begin
                if (i_status.out_free) begin
                    w_cmd   = CMD_HIT;
                    n_state = S_IDLE;
                end
            end
            S_MISS: begin
                w_cmd   = CMD_MISS_SETUP;
                n_state = i_status.free_found ? S_COMMIT : S_EVICT;
            end
            S_EVICT: begin
                if (i_status.ev_sel) begin
                    w_cmd   = CMD_EVICT_PICK;
                    n_state = S_VREAD;
                end else begin
                    w_cmd = CMD_EVICT_STEP;
                end
            end
            S_VREAD: begin
                w_cmd   = CMD_VICTIM_READ;
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_status.out_free) begin
                    w_cmd   = CMD_COMMIT;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_status.scan_done) begin
                    n_state = S_FEND;
                end else if (!i_status.flush_stall) begin
                    w_cmd = CMD_FLUSH_STEP;
                end
            end
            S_FEND: begin
                if (i_status.out_free) begin
                    w_cmd   = CMD_FLUSH_END;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_rdy <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_in_rdy <= (n_state == S_IDLE);
        end
    end

endmodule

// ----- sv/sector_cache_clock_controller.sv -----
`timescale 1ns / 1ps
// Top level of the sector cache tag and clock replacement controller.
// Instantiates scc_ctrl and scc_dp; depends on scc_pkg.
//
// This block keeps the tags and the valid, dirty and referenced bits of a
// write-back cache of SLOT_COUNT disk sectors and answers one request at a
// time. A read or write request walks the tag memory one slot per clock
// and stops at a hit; a miss with a free slot finishes after the full walk.
// A miss with no free slot then runs the clock hand, one slot per cycle;
// the sweep always settles within its first three laps, because the second
// lap leaves every clean slot unreferenced. A flush walks every slot once
// and gives one result per dirty slot, or one bare final result if no slot
// is dirty; it waits while the result register is held by the consumer.
// Requests with offset plus count above SECTOR_BYTES, or with the unused
// opcode, are refused with no change of state. Each result sits in an
// output register, so the next request can be taken while the last result
// of the previous one still waits to be picked up; a result with
// final_result set closes its request. Slot tags are not cleared at reset
// and are only ever compared against a slot whose valid bit is set, so no
// clearing pass is needed.
module sector_cache_clock_controller #(
    parameter int SLOT_COUNT   = scc_pkg::DEF_SLOT_COUNT,
    parameter int SECTOR_BYTES = scc_pkg::DEF_SECTOR_BYTES,
    parameter int SECTOR_BITS  = scc_pkg::DEF_SECTOR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [scc_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [SECTOR_BITS-1:0]              i_sector,
    input  logic [$clog2(SECTOR_BYTES)-1:0]     i_byte_offset,
    input  logic [$clog2(SECTOR_BYTES+1)-1:0]   i_byte_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [$clog2(SLOT_COUNT)-1:0]       o_slot,
    output logic                                o_hit,
    output logic                                o_fill_needed,
    output logic                                o_writeback_needed,
    output logic [SECTOR_BITS-1:0]              o_writeback_sector,
    output logic                                o_rejected,
    output logic                                o_final_result
);
    import scc_pkg::*;

    // Commands flow from the controller to the datapath; status flows back.
    t_cmd    w_cmd;
    t_status w_status;

    scc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    scc_dp #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_BITS  (SECTOR_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_opcode           (i_opcode),
        .i_sector           (i_sector),
        .i_byte_offset      (i_byte_offset),
        .i_byte_count       (i_byte_count),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_slot             (o_slot),
        .o_hit              (o_hit),
        .o_fill_needed      (o_fill_needed),
        .o_writeback_needed (o_writeback_needed),
        .o_writeback_sector (o_writeback_sector),
        .o_rejected         (o_rejected),
        .o_final_result     (o_final_result)
    );

`ifndef NO_ASSERTIONS
    // A hit never moves data to or from the disk and always closes its request.
    a_hit_no_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit |-> !o_fill_needed && !o_writeback_needed && o_final_result)
        else $error("hit result requests a disk transfer or is not final");

    // A refused request gives a single bare result.
    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_final_result && !o_hit && !o_fill_needed
                                      && !o_writeback_needed)
        else $error("refused request result carries other flags");

    // The writeback sector is zero whenever no writeback is asked for.
    a_wb_sector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_writeback_needed |-> o_writeback_sector == '0)
        else $error("writeback sector set without a writeback");

    // Once a request is taken, no other is taken in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while the previous one is in progress");
`endif

endmodule
